// ----- src/olas_pkg.sv -----
// Package: shared codes, field widths and control types for the ordered list unit.
`timescale 1ns / 1ps

package olas_pkg;

    localparam int ACTION_W = 2;
    localparam int VALUE_W  = 8;
    localparam int STATUS_W = 2;
    localparam int MATCH_W  = 4;
    localparam int COUNT_W  = 5;

    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } olas_state_t;

    typedef struct packed {
        logic cmp_en;
        logic wr_app;
        logic shift;
    } olas_cell_ctrl_t;

endpackage

// ----- src/olas_if.sv -----
// Interfaces: request and response channels with valid/ready handshake.
`timescale 1ns / 1ps

interface olas_req_if import olas_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [VALUE_W-1:0]  item_value;

    modport source (output valid, output action, output item_value, input ready);
    modport sink   (input valid, input action, input item_value, output ready);
endinterface

interface olas_rsp_if import olas_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [MATCH_W-1:0]  match_position;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output match_position, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input match_position, input entry_count,
                    output ready);
endinterface

// ----- src/ordered_list_append_search_delete_unit.sv -----
// Top level: ordered byte list built as a row of cells with compare and shift-to-close.
// Sequence: a transferred request goes through the compare state, then the update state,
//   which registers the response; a new request is taken only back in idle, after the
//   update; the update waits while the response register is full.
// Reset: asynchronous, clears the entry count, state machine and response valid;
//   cell contents are not reset and are read only after being written.
`timescale 1ns / 1ps

module ordered_list_append_search_delete_unit import olas_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    olas_req_if.sink     req,
    olas_rsp_if.source   rsp
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    olas_state_t         state_reg;
    olas_state_t         state_next;
    logic [ACTION_W-1:0] action_reg;
    logic [VALUE_W-1:0]  key_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [MATCH_W-1:0]  match_reg;
    logic [COUNT_W-1:0]  ecount_reg;

    logic                in_ready;
    logic                cmp_en;
    logic                commit;
    logic                full;
    logic                app_ok;
    logic                del_ok;
    logic [STATUS_W-1:0] status_new;
    logic [IW-1:0]       pos_new;

    logic [VALUE_W-1:0]  cell_value [DEPTH];
    logic [DEPTH-1:0]    hit;
    logic [DEPTH-1:0]    at_or_after;
    logic                found;
    logic [IW-1:0]       position;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmp_en   = 1'b0;
        commit   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_CMP:
            begin
                cmp_en = 1'b1;
            end
            S_UPD:
            begin
                commit = !out_valid_reg || rsp.ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign req.ready = in_ready;

    olas_first #(
        .DEPTH (DEPTH)
    ) u_first (
        .hit         (hit),
        .at_or_after (at_or_after),
        .found       (found),
        .position    (position)
    );

    assign full   = (count_reg == CW'(DEPTH));
    assign app_ok = (action_reg == ACT_APPEND) && !full;
    assign del_ok = (action_reg == ACT_DELETE) && found;

    always_comb
    begin
        status_new = ST_MISS;
        pos_new    = '0;
        count_next = count_reg;
        case (action_reg)
            ACT_APPEND:
            begin
                if (full)
                begin
                    status_new = ST_FULL;
                end
                else
                begin
                    status_new = ST_DONE;
                    count_next = count_reg + CW'(1);
                end
            end
            ACT_SEARCH:
            begin
                if (found)
                begin
                    status_new = ST_DONE;
                    pos_new    = position;
                end
            end
            ACT_DELETE:
            begin
                if (found)
                begin
                    status_new = ST_DONE;
                    pos_new    = position;
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
                status_new = ST_MISS;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            olas_cell_ctrl_t    ctrl;
            logic [VALUE_W-1:0] nbr;

            assign ctrl.cmp_en = cmp_en;
            assign ctrl.wr_app = commit && app_ok && (count_reg == CW'(gi));
            // close the gap: every cell from the first match on takes its neighbor
            assign ctrl.shift  = commit && del_ok && at_or_after[gi];

            if (gi == DEPTH - 1)
            begin : g_tail
                assign nbr = cell_value[gi];
            end
            else
            begin : g_body
                assign nbr = cell_value[gi + 1];
            end

            olas_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .key        (key_reg),
                .next_value (nbr),
                .in_range   (count_reg > CW'(gi)),
                .value      (cell_value[gi]),
                .hit        (hit[gi])
            );
        end
    endgenerate

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && req.valid)
        begin
            action_reg <= req.action;
            key_reg    <= req.item_value;
        end
        if (commit)
        begin
            status_reg <= status_new;
            match_reg  <= MATCH_W'(pos_new);
            ecount_reg <= COUNT_W'(count_next);
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.match_position = match_reg;
    assign rsp.entry_count    = ecount_reg;

endmodule

// ----- src/olas_cell.sv -----
// Storage cell: one list entry, its key compare, and the shift path from its neighbor.
`timescale 1ns / 1ps

module olas_cell import olas_pkg::*;
(
    input  logic                 clk,
    input  olas_cell_ctrl_t      ctrl,
    input  logic [VALUE_W-1:0]   key,
    input  logic [VALUE_W-1:0]   next_value,
    input  logic                 in_range,
    output logic [VALUE_W-1:0]   value,
    output logic                 hit
);

    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic               hit_reg;
    logic               hit_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.wr_app)
        begin
            value_next = key;
        end
        else if (ctrl.shift)
        begin
            value_next = next_value;
        end
        hit_next = hit_reg;
        if (ctrl.cmp_en)
        begin
            hit_next = in_range && (value_reg == key);
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        hit_reg   <= hit_next;
    end

    assign value = value_reg;
    assign hit   = hit_reg;

endmodule

// ----- src/olas_first.sv -----
// First-match finder: prefix OR over cell hits, first-hit position and found flag.
`timescale 1ns / 1ps

module olas_first #(
    parameter int DEPTH = 16
)
(
    input  logic [DEPTH-1:0]         hit,
    output logic [DEPTH-1:0]         at_or_after,
    output logic                     found,
    output logic [$clog2(DEPTH)-1:0] position
);

    localparam int IW = $clog2(DEPTH);

    logic [DEPTH-1:0] pre;
    logic [DEPTH-1:0] first;

    // log-depth prefix OR: pre[i] = any hit at index 0..i
    always_comb
    begin
        pre = hit;
        for (int s = 1; s < DEPTH; s = s * 2)
        begin
            pre = pre | (pre << s);
        end
    end

    always_comb
    begin
        first    = hit & ~(pre << 1);
        position = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (first[i])
            begin
                position = position | IW'(i);
            end
        end
    end

    assign at_or_after = pre;
    assign found       = pre[DEPTH-1];

endmodule
